@@ hdl/mru_pkg.sv @@
// ----------------------------------------------------------------------------
// mru_pkg
// Shared constants, controller states and control structs for the MRU
// page-replacement frame manager.
// ----------------------------------------------------------------------------
package mru_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed port widths
  localparam int PAGE_IN_W = 16;
  localparam int IDX_OUT_W = 4;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // load request register from input beat
    logic execute;   // search, update frames, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_blocked;  // result register full and not being taken
  } status_t;

endpackage

@@ hdl/mru_ctrl.sv @@
// ----------------------------------------------------------------------------
// mru_ctrl
// Two-state controller: take one request beat, then run the lookup/update
// once the result register can take the answer.
// ----------------------------------------------------------------------------
module mru_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mru_pkg::status_t status,
  output mru_pkg::cmd_t    cmd
);

  mru_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      mru_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = mru_pkg::ST_BUSY;
        end
      end
      mru_pkg::ST_BUSY: begin
        if (!status.out_blocked) begin
          cmd.execute = 1'b1;
          state_nxt   = mru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mru_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/mru_dp.sv @@
// ----------------------------------------------------------------------------
// mru_dp
// Frame table, parallel page compare, fill/replace slot choice, fault
// counter and the result register.
// ----------------------------------------------------------------------------
module mru_dp #(
  parameter int FRAMES    = mru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = mru_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mru_pkg::cmd_t                 cmd,
  output mru_pkg::status_t              status,
  input  logic                          cfg_we,
  input  logic [mru_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [mru_pkg::PAGE_IN_W-1:0] in_page_number,
  input  logic                          in_last_request,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [mru_pkg::IDX_OUT_W-1:0] out_frame_index,
  output logic                          out_evicted_valid,
  output logic [mru_pkg::PAGE_IN_W-1:0] out_evicted_page,
  output logic [mru_pkg::CNT_W-1:0]     out_fault_count,
  output logic                          out_final_total
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;  // frame index
  localparam int CW = $clog2(FRAMES + 1);                 // frame count

  // configuration
  logic [mru_pkg::CFG_W-1:0] cfg_r;

  // request register
  logic [31:0]          page_ext;
  logic [PAGE_BITS-1:0] req_page_r;
  logic                 req_last_r;

  // frame table
  logic [PAGE_BITS-1:0] pages_r [FRAMES];
  logic [FRAMES-1:0]    valid_r, valid_nxt;
  logic [CW-1:0]        filled_r, filled_nxt;
  logic [IW-1:0]        recent_r, recent_nxt;
  logic [mru_pkg::CNT_W-1:0] faults_r, faults_nxt;

  // lookup
  logic [CW-1:0]        n_act;
  logic [FRAMES-1:0]    match;
  logic                 hit;
  logic [IW-1:0]        hit_idx;
  logic                 fill;
  logic [IW-1:0]        slot;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;
  logic [31:0]          slot_ext, ev_ext;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic                          hit_r;
  logic [mru_pkg::IDX_OUT_W-1:0] idx_r;
  logic                          evv_r;
  logic [mru_pkg::PAGE_IN_W-1:0] evp_r;
  logic [mru_pkg::CNT_W-1:0]     cnt_r;
  logic                          fin_r;

  assign page_ext = 32'(in_page_number);

  // effective frame count, clamped to 1..FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      n_act = CW'(1);
    end else if (32'(cfg_r) > FRAMES) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(cfg_r);
    end
  end

  // lowest matching frame wins (upper frames may hold stale copies after
  // the frame count grows)
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = valid_r[i] && (pages_r[i] == req_page_r) && (32'(i) < 32'(n_act));
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (match[i] && !hit) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_comb begin
    fill = !hit && (filled_r < n_act);
    if (hit) begin
      slot = hit_idx;
    end else if (fill) begin
      slot = filled_r[IW-1:0];
    end else if (CW'(recent_r) < n_act) begin
      slot = recent_r;
    end else begin
      slot = '0;
    end
    ev_valid = !hit && valid_r[slot];
    ev_page  = ev_valid ? pages_r[slot] : '0;
  end

  assign slot_ext = 32'(slot);
  assign ev_ext   = 32'(ev_page);

  always_comb begin
    valid_nxt  = valid_r;
    filled_nxt = filled_r;
    recent_nxt = recent_r;
    faults_nxt = faults_r;
    if (cmd.execute) begin
      if (!hit) begin
        valid_nxt[slot] = 1'b1;
        if (faults_r != mru_pkg::COUNT_MAX) begin
          faults_nxt = faults_r + 1'b1;
        end
      end
      if (fill) begin
        filled_nxt = filled_r + 1'b1;
      end
      recent_nxt = slot;
      if (req_last_r) begin
        valid_nxt  = '0;
        filled_nxt = '0;
        recent_nxt = '0;
        faults_nxt = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign status.out_blocked = out_valid_r && out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= mru_pkg::CFG_RESET;
      valid_r     <= '0;
      filled_r    <= '0;
      recent_r    <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      valid_r     <= valid_nxt;
      filled_r    <= filled_nxt;
      recent_r    <= recent_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_page_r <= page_ext[PAGE_BITS-1:0];
      req_last_r <= in_last_request;
    end
    if (cmd.execute) begin
      if (!hit) begin
        pages_r[slot] <= req_page_r;
      end
      hit_r <= hit;
      idx_r <= slot_ext[mru_pkg::IDX_OUT_W-1:0];
      evv_r <= ev_valid;
      evp_r <= ev_ext[mru_pkg::PAGE_IN_W-1:0];
      cnt_r <= (!hit && faults_r != mru_pkg::COUNT_MAX) ? faults_r + 1'b1 : faults_r;
      fin_r <= req_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_frame_index   = idx_r;
  assign out_evicted_valid = evv_r;
  assign out_evicted_page  = evp_r;
  assign out_fault_count   = cnt_r;
  assign out_final_total   = fin_r;

endmodule

@@ hdl/mru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// mru_page_replacement
// Demand-paging frame manager with most-recently-used replacement: one
// result beat per request beat, with hit/frame/eviction and fault count.
// ----------------------------------------------------------------------------
//
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_stall, in_page_number,              | in
//          | in_last_request                                  |
//  out     | out_valid, out_stall, out_hit, out_frame_index,  | out
//          | out_evicted_valid, out_evicted_page,             |
//          | out_fault_count, out_final_total                 |
//  cfg     | cfg_we, cfg_wdata (frames_in_use)                | in
//
//  Per request beat: the beat is first taken into the request register;
//    then the parallel tag compare, slot choice and frame table update
//    run and load the result register.
//  The result register decouples the sides: a new request beat is taken
//    while the previous result still waits on out_stall; the update cycle
//    is held off until the result register is free.
//  Reset: synchronous, active low; clears frame valid bits, fill count,
//    recent frame, fault counter and sets frames_in_use to 3. No clearing
//    pass; the block takes beats right after reset.
//  A beat with in_last_request set reports the final fault total and then
//    empties all frames and zeroes the counter.
//
module mru_page_replacement #(
  parameter int FRAMES    = mru_pkg::FRAMES_DEF,     // 1..16
  parameter int PAGE_BITS = mru_pkg::PAGE_BITS_DEF   // 4..32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [mru_pkg::CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mru_pkg::PAGE_IN_W-1:0] in_page_number,
  input  logic                          in_last_request,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [mru_pkg::IDX_OUT_W-1:0] out_frame_index,
  output logic                          out_evicted_valid,
  output logic [mru_pkg::PAGE_IN_W-1:0] out_evicted_page,
  output logic [mru_pkg::CNT_W-1:0]     out_fault_count,
  output logic                          out_final_total
);

  mru_pkg::cmd_t    cmd;
  mru_pkg::status_t status;

  mru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mru_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_page_number    (in_page_number),
    .in_last_request   (in_last_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .out_final_total   (out_final_total)
  );

  // one request in flight: an accepted beat blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request beat taken while previous still in progress");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  // a fault always shows a nonzero count
  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_fault_count != '0))
    else $error("fault reported with zero fault count");

endmodule

@@ verif/mru_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_checker
// Watches the config port and both beat channels of the MRU frame manager,
// keeps its own frame table and fault count, and checks every result beat.
// ----------------------------------------------------------------------------
module mru_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mru_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mru_pkg::PAGE_IN_W-1:0] in_page_number,
  input  logic                          in_last_request,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_hit,
  input  logic [mru_pkg::IDX_OUT_W-1:0] out_frame_index,
  input  logic                          out_evicted_valid,
  input  logic [mru_pkg::PAGE_IN_W-1:0] out_evicted_page,
  input  logic [mru_pkg::CNT_W-1:0]     out_fault_count,
  input  logic                          out_final_total,
  output int                            fail_count,
  output int                            req_count,
  output int                            resp_count
);
  import mru_pkg::*;

  localparam int NFRAMES = FRAMES_DEF;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame;
    logic                 ev_valid;
    logic [PAGE_IN_W-1:0] ev_page;
    logic [CNT_W-1:0]     faults;
    logic                 final_total;
  } page_report_t;

  // shadow frame table
  logic [PAGE_IN_W-1:0] page_tbl [NFRAMES];
  logic                 tbl_valid [NFRAMES];
  int                   filled;
  int                   recent;
  logic [CNT_W-1:0]     faults;
  logic [CFG_W-1:0]     frames_cfg;

  page_report_t expected_reports [$];

  initial fail_count = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fail_count < 30)
      $display("mismatch @%0t: %s got %h want %h (result %0d)",
               $realtime, what, got, want, resp_count);
    fail_count++;
  endtask

  task automatic clear_string();
    int i;
    for (i = 0; i < NFRAMES; i++) begin
      page_tbl[i]  = '0;
      tbl_valid[i] = 1'b0;
    end
    filled = 0;
    recent = 0;
    faults = '0;
  endtask

  // one request through the MRU policy
  task automatic resolve_request(input logic [PAGE_IN_W-1:0] page, input logic last,
                                 output page_report_t r);
    int n;
    int i;
    int slot;
    bit found;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES) ? NFRAMES : int'(frames_cfg);
    found = 1'b0;
    slot  = 0;
    for (i = 0; i < n; i++)
      if (!found && tbl_valid[i] && page_tbl[i] == page) begin
        found = 1'b1;
        slot  = i;
      end
    r = '0;
    r.hit = found;
    if (!found) begin
      if (filled < n) begin
        slot = filled;
        filled++;
      end else begin
        slot = (recent < n) ? recent : 0;
      end
      if (tbl_valid[slot]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = page_tbl[slot];
      end
      page_tbl[slot]  = page;
      tbl_valid[slot] = 1'b1;
      if (faults != COUNT_MAX) faults++;
    end
    recent = slot;
    r.frame       = slot[IDX_OUT_W-1:0];
    r.faults      = faults;
    r.final_total = last;
    if (last) clear_string();
  endtask

  task automatic compare_report(input page_report_t got, input page_report_t want);
    if (got.hit !== want.hit)
      flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
    if (got.frame !== want.frame)
      flag_mismatch("frame_index", 32'(got.frame), 32'(want.frame));
    if (got.ev_valid !== want.ev_valid)
      flag_mismatch("evicted_valid", 32'(got.ev_valid), 32'(want.ev_valid));
    if (got.ev_page !== want.ev_page)
      flag_mismatch("evicted_page", 32'(got.ev_page), 32'(want.ev_page));
    if (got.faults !== want.faults)
      flag_mismatch("fault_count", 32'(got.faults), 32'(want.faults));
    if (got.final_total !== want.final_total)
      flag_mismatch("final_total", 32'(got.final_total), 32'(want.final_total));
  endtask

  always @(posedge clk) begin : watch
    page_report_t got_r;
    page_report_t want_r;
    if (!rst_n) begin
      clear_string();
      frames_cfg = CFG_RESET;
      expected_reports.delete();
      req_count  <= 0;
      resp_count <= 0;
    end else begin
      if (cfg_we === 1'b1) frames_cfg = cfg_wdata;
      // result side first: a beat taken this edge cannot answer one taken now
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got_r.hit         = out_hit;
        got_r.frame       = out_frame_index;
        got_r.ev_valid    = out_evicted_valid;
        got_r.ev_page     = out_evicted_page;
        got_r.faults      = out_fault_count;
        got_r.final_total = out_final_total;
        resp_count <= resp_count + 1;
        if (expected_reports.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding", 0, 0);
        end else begin
          want_r = expected_reports.pop_front();
          compare_report(got_r, want_r);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        resolve_request(in_page_number, in_last_request, want_r);
        expected_reports.push_back(want_r);
        req_count <= req_count + 1;
      end
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MRU frame manager: directed reference strings
// for fill, hit, MRU replacement, frame-count clamping and shrinking, then
// random strings over random frame counts with bursty requests and a
// stalling result side.
// ----------------------------------------------------------------------------
module tb;
  import mru_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;    // worst case stalls stay far below
  localparam int RANDOM_ITEMS = 1800;
  localparam int SETTLE       = 4;          // margin after the last result beat
  localparam int POOL_MAX     = 20;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic [PAGE_IN_W-1:0] in_page_number  = '0;
  logic                 in_last_request = 1'b0;
  logic                 out_stall       = 1'b0;

  logic                 in_stall;
  logic                 out_valid;
  logic                 out_hit;
  logic [IDX_OUT_W-1:0] out_frame_index;
  logic                 out_evicted_valid;
  logic [PAGE_IN_W-1:0] out_evicted_page;
  logic [CNT_W-1:0]     out_fault_count;
  logic                 out_final_total;

  int fail_count;
  int req_count;
  int resp_count;
  int cycles      = 0;
  int settings    = 0;
  int rand_sent   = 0;
  bit bursty      = 1'b0;
  int burst_left  = 1;
  int pool [POOL_MAX];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mru_page_replacement u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .in_last_request   (in_last_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .out_final_total   (out_final_total)
  );

  mru_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .in_last_request   (in_last_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .out_final_total   (out_final_total),
    .fail_count        (fail_count),
    .req_count         (req_count),
    .resp_count        (resp_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side: open runs, short stall runs, now and then a long open stretch
  initial begin
    int  run;
    bit  hold;
    @(posedge clk);
    forever begin
      case ($urandom_range(0, 7))
        0: begin
          hold = 1'b0;
          run  = $urandom_range(50, 200);
        end
        1, 2: begin
          hold = 1'b1;
          run  = $urandom_range(1, 6);
        end
        default: begin
          hold = 1'b0;
          run  = $urandom_range(1, 12);
        end
      endcase
      out_stall <= hold;
      repeat (run) @(posedge clk);
    end
  end

  // present one request beat and hold it until taken; valid stays up
  task automatic send_beat(input logic [PAGE_IN_W-1:0] page, input logic last);
    in_valid        <= 1'b1;
    in_page_number  <= page;
    in_last_request <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // request beat followed by a burst gap when the sender is bursty
  task automatic paced_beat(input logic [PAGE_IN_W-1:0] page, input logic last);
    int gap;
    send_beat(page, last);
    if (bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every outstanding result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (req_count != resp_count) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // frame count only changes with the block idle
  task automatic write_frames(input int count);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= count[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  initial begin
    int i;
    int k;
    int s;
    int strings;
    int len;
    int pool_size;
    int pick;
    bit broken;
    logic [PAGE_IN_W-1:0] page;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset frame count of 3, fill / hit / MRU replacement
    bursty = 1'b0;
    paced_beat(16'h0000, 1'b0);  // fills frame 0
    paced_beat(16'hFFFF, 1'b0);  // frame 1
    paced_beat(16'h0000, 1'b0);  // hit
    paced_beat(16'h1234, 1'b0);  // frame 2, now full
    paced_beat(16'h5555, 1'b0);  // MRU is frame 2 -> evicts 1234
    paced_beat(16'h5555, 1'b0);  // hit
    paced_beat(16'hAAAA, 1'b0);  // evicts 5555 again
    paced_beat(16'hFFFF, 1'b0);  // hit on frame 1
    paced_beat(16'h0F0F, 1'b0);  // frame 1 was most recent -> evict FFFF
    paced_beat(16'h0F0F, 1'b1);  // last request on a hit
    paced_beat(16'h0000, 1'b1);  // one-beat string after clear

    // frame count shrunk mid-string: MRU frame 7 lies outside, frame 0 goes
    write_frames(8);
    for (i = 0; i < 8; i++) paced_beat(16'h0100 + i[15:0], 1'b0);
    write_frames(3);
    paced_beat(16'h0105, 1'b0);  // held in frame 5, not searched -> miss
    paced_beat(16'h0101, 1'b1);  // still hits frame 1

    // out-of-range counts: 0 acts as one frame, above 16 acts as 16
    write_frames(0);
    paced_beat(16'h0007, 1'b0);
    paced_beat(16'h0007, 1'b0);
    paced_beat(16'h0009, 1'b1);
    write_frames(17);
    for (i = 0; i < 17; i++) paced_beat(16'h8000 ^ i[15:0], i == 16);
    write_frames(31);
    paced_beat(16'h00FF, 1'b0);
    paced_beat(16'h00FF, 1'b1);

    // --- random strings over random frame counts
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       write_frames(0);
        1:       write_frames($urandom_range(17, 31));
        2:       write_frames(16);
        3:       write_frames(1);
        default: write_frames($urandom_range(1, 16));
      endcase
      bursty     = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 16);
      pool_size  = $urandom_range(1, POOL_MAX);
      for (i = 0; i < pool_size; i++) pool[i] = $urandom_range(0, 65535);
      strings = $urandom_range(1, 6);
      for (s = 0; s < strings; s++) begin
        len    = $urandom_range(1, 30);
        broken = ($urandom_range(0, 9) == 0);  // string runs on without a last flag
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 6) == 0) begin
            page = PAGE_IN_W'($urandom);       // noise page, mostly a miss
          end else begin
            pick = $urandom_range(0, pool_size - 1);
            page = pool[pick][PAGE_IN_W-1:0];
          end
          paced_beat(page, (k == len - 1) && !broken);
          rand_sent++;
        end
        if ($urandom_range(0, 15) == 0) drain();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (req_count != resp_count) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("summary: %0d requests, %0d results, %0d frame-count writes incl. 0 and >16,",
             req_count, resp_count, settings);
    $display("summary: mid-string shrink, out-of-range counts, bursty sender, stalled receiver");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
